// ----- rtl/ske_pkg.sv -----
// Shared types, constants and helpers for the sortable key part encoder.
`timescale 1ns / 1ps

package ske_pkg;

    // Result burst sizing: one input transaction causes at most MAX_RES bytes
    localparam int MAX_RES    = 12;
    localparam int RES_W      = 4;
    localparam int HOLD_DEPTH = 8;
    localparam int HOLD_W     = 3;
    localparam int HELD_W     = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_MARKER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MARKER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_TAG        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_TAG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATETIME_TAG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OTHER_TAG      = 3'd5;

    // Configuration reset values
    localparam logic [7:0] RST_NULL_MARKER    = 8'd0;
    localparam logic [7:0] RST_PRESENT_MARKER = 8'd1;
    localparam logic [7:0] RST_INT_TAG        = 8'd1;
    localparam logic [7:0] RST_STRING_TAG     = 8'd2;
    localparam logic [7:0] RST_DATETIME_TAG   = 8'd3;
    localparam logic [7:0] RST_OTHER_TAG      = 8'd4;

    // Key part type codes
    localparam logic [1:0] TYPE_INT      = 2'd0;
    localparam logic [1:0] TYPE_STRING   = 2'd1;
    localparam logic [1:0] TYPE_DATETIME = 2'd2;
    localparam logic [1:0] TYPE_OTHER    = 2'd3;

    // Byte constants
    localparam logic [7:0]  SIGN_FLIP   = 8'h80;
    localparam logic [7:0]  TERMINATOR  = 8'h00;
    localparam logic [15:0] DATE_LENGTH = 16'd3;

    typedef struct packed {
        logic        part_start;
        logic [1:0]  part_type;
        logic        is_null;
        logic        date_reorder;
        logic [15:0] part_length;
        logic        has_byte;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] null_marker;
        logic [7:0] present_marker;
        logic [7:0] int_tag;
        logic [7:0] string_tag;
        logic [7:0] datetime_tag;
        logic [7:0] other_tag;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       part_end;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [RES_W-1:0]   cnt;
    } t_burst;

    // Integer lengths that are buffered and re-emitted
    function automatic logic len_ok(input logic [15:0] len);
        return (len == 16'd1) || (len == 16'd2) || (len == 16'd4) || (len == 16'd8);
    endfunction

endpackage

// ----- rtl/sortable_key_part_encoder_unit.sv -----
// Top level of the sortable key part encoder: input register, configuration, output.
`timescale 1ns / 1ps

// Turns a stream of key part payload bytes into an order-preserving, byte-comparable
// key encoding. Each input transaction is taken into an input register and encoded
// combinationally into a burst of up to eight result bytes, which then leave on the
// output channel at one byte per cycle unless the output stalls; the single byte-wide
// output port sets this rate. A transaction causes two to seven bytes for a part start,
// one for a plain payload byte, one for a string byte but four for the last one of the
// part, three at the end of a reordered date, up to eight at the end of an integer part,
// and none for a byte that is only buffered. A new input transaction is taken every
// cycle while the output keeps up; a transaction passes the input register and then the
// burst register before its first result byte. Configuration registers may be written
// only while the block is idle.
module sortable_key_part_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [ske_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_part_start,
    input  logic [1:0]                    i_part_type,
    input  logic                          i_is_null,
    input  logic                          i_date_reorder,
    input  logic [15:0]                   i_part_length,
    input  logic                          i_has_byte,
    input  logic [7:0]                    i_data_byte,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_part_end
);
    import ske_pkg::*;

    t_cfg   r_cfg;
    t_item  r_item;
    logic   r_in_valid;
    t_burst w_burst;
    logic   w_can_load;
    logic   w_consume;
    logic   w_in_accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.null_marker    <= RST_NULL_MARKER;
            r_cfg.present_marker <= RST_PRESENT_MARKER;
            r_cfg.int_tag        <= RST_INT_TAG;
            r_cfg.string_tag     <= RST_STRING_TAG;
            r_cfg.datetime_tag   <= RST_DATETIME_TAG;
            r_cfg.other_tag      <= RST_OTHER_TAG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NULL_MARKER:    r_cfg.null_marker    <= i_cfg_data;
                CFG_PRESENT_MARKER: r_cfg.present_marker <= i_cfg_data;
                CFG_INT_TAG:        r_cfg.int_tag        <= i_cfg_data;
                CFG_STRING_TAG:     r_cfg.string_tag     <= i_cfg_data;
                CFG_DATETIME_TAG:   r_cfg.datetime_tag   <= i_cfg_data;
                CFG_OTHER_TAG:      r_cfg.other_tag      <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Input register moves on when its burst fits or it causes no bytes
    assign w_consume   = r_in_valid && ((w_burst.cnt == '0) || w_can_load);
    assign o_stall     = r_in_valid && !w_consume;
    assign w_in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item <= '{part_start:   i_part_start,
                        part_type:    i_part_type,
                        is_null:      i_is_null,
                        date_reorder: i_date_reorder,
                        part_length:  i_part_length,
                        has_byte:     i_has_byte,
                        data_byte:    i_data_byte};
        end
    end

    // Encoder core
    ske_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_consume),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_burst (w_burst)
    );

    // Output serializer
    ske_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_consume && (w_burst.cnt != '0)),
        .i_burst    (w_burst),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_part_end (o_part_end)
    );

    // The part's closing byte is always the final byte of its transaction
    a_part_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_part_end) |-> o_run_last)
        else $error("part end byte not last of its transaction");

    // No transaction causes more bytes than a full integer trailer
    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (w_burst.cnt <= RES_W'(HOLD_DEPTH)))
        else $error("result burst longer than expected");

    // Input back-pressure only while a transaction waits in the input register
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && !w_can_load))
        else $error("input stalled without a waiting transaction");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ----- rtl/ske_core.sv -----
// Encoder core: part state, integer/date hold buffer and per-transaction burst build.
`timescale 1ns / 1ps

module ske_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  ske_pkg::t_item  i_item,
    input  ske_pkg::t_cfg   i_cfg,
    output ske_pkg::t_burst o_burst
);
    import ske_pkg::*;

    // Part state
    logic [15:0]       r_bytes_left, n_bytes_left;
    logic [1:0]        r_type, n_type;
    logic              r_reorder, n_reorder;
    logic [15:0]       r_decl_len, n_decl_len;
    logic [HELD_W-1:0] r_held, n_held;
    logic [7:0]        r_hold [HOLD_DEPTH];
    logic [7:0]        n_hold [HOLD_DEPTH];

    // Burst build
    t_res [MAX_RES-1:0] w_res;
    logic [RES_W-1:0]   w_k;
    logic               w_take;
    logic               w_finish;
    logic [15:0]        w_field;
    logic               w_end_hdr;
    logic [7:0]         w_tag;

    // Tag for the type of the incoming start transaction
    always_comb begin
        unique case (i_item.part_type)
            TYPE_INT:      w_tag = i_cfg.int_tag;
            TYPE_STRING:   w_tag = i_cfg.string_tag;
            TYPE_DATETIME: w_tag = i_cfg.datetime_tag;
            default:       w_tag = i_cfg.other_tag;
        endcase
    end

    // Next state and result bytes for the transaction in the input register
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_type       = r_type;
        n_reorder    = r_reorder;
        n_decl_len   = r_decl_len;
        n_held       = r_held;
        n_hold       = r_hold;
        w_res        = '0;
        w_k          = '0;
        w_take       = 1'b0;
        w_finish     = 1'b0;
        w_field      = '0;
        w_end_hdr    = 1'b0;

        // Header bytes on a part start
        if (i_item.part_start) begin
            n_type    = i_item.part_type;
            n_reorder = (i_item.part_type == TYPE_DATETIME) ? i_item.date_reorder : 1'b0;
            n_held    = '0;
            if (i_item.is_null) begin
                n_bytes_left = '0;
                n_decl_len   = '0;
                w_res[w_k] = '{data: i_cfg.null_marker, part_end: 1'b0};
                w_k = w_k + 1'b1;
                w_res[w_k] = '{data: w_tag, part_end: 1'b0};
                w_k = w_k + 1'b1;
                if (i_item.part_type == TYPE_STRING) begin
                    w_res[w_k] = '{data: TERMINATOR, part_end: 1'b0};
                    w_k = w_k + 1'b1;
                end
                w_res[w_k] = '{data: 8'h00, part_end: 1'b0};
                w_k = w_k + 1'b1;
                w_res[w_k] = '{data: 8'h00, part_end: 1'b1};
                w_k = w_k + 1'b1;
            end else begin
                n_decl_len   = i_item.part_length;
                n_bytes_left = i_item.part_length;
                w_res[w_k] = '{data: i_cfg.present_marker, part_end: 1'b0};
                w_k = w_k + 1'b1;
                w_res[w_k] = '{data: w_tag, part_end: 1'b0};
                w_k = w_k + 1'b1;
                if (i_item.part_type != TYPE_STRING) begin
                    if (i_item.part_type == TYPE_INT) begin
                        w_field   = len_ok(i_item.part_length) ? i_item.part_length : 16'd0;
                        w_end_hdr = !len_ok(i_item.part_length);
                    end else if (n_reorder) begin
                        w_field   = DATE_LENGTH;
                        w_end_hdr = 1'b0;
                    end else begin
                        w_field   = i_item.part_length;
                        w_end_hdr = (i_item.part_length == 16'd0);
                    end
                    w_res[w_k] = '{data: w_field[15:8], part_end: 1'b0};
                    w_k = w_k + 1'b1;
                    w_res[w_k] = '{data: w_field[7:0], part_end: w_end_hdr};
                    w_k = w_k + 1'b1;
                end
                if (i_item.part_length == 16'd0) begin
                    w_finish = 1'b1;
                end else begin
                    w_take = i_item.has_byte;
                end
            end
        end else begin
            w_take = (r_bytes_left != 16'd0) && i_item.has_byte;
        end

        // Payload byte
        if (w_take) begin
            n_bytes_left = n_bytes_left - 16'd1;
            unique case (n_type)
                TYPE_INT: begin
                    if (len_ok(n_decl_len) && (n_held < HELD_W'(HOLD_DEPTH))) begin
                        n_hold[n_held[HOLD_W-1:0]] = i_item.data_byte;
                        n_held = n_held + 1'b1;
                    end
                end
                TYPE_STRING: begin
                    w_res[w_k] = '{data: i_item.data_byte, part_end: 1'b0};
                    w_k = w_k + 1'b1;
                end
                TYPE_DATETIME: begin
                    if (n_reorder) begin
                        if (n_held < HELD_W'(DATE_LENGTH)) begin
                            n_hold[n_held[HOLD_W-1:0]] = i_item.data_byte;
                            n_held = n_held + 1'b1;
                        end
                    end else begin
                        w_res[w_k] = '{data: i_item.data_byte,
                                       part_end: (n_bytes_left == 16'd0)};
                        w_k = w_k + 1'b1;
                    end
                end
                default: begin
                    w_res[w_k] = '{data: i_item.data_byte,
                                   part_end: (n_bytes_left == 16'd0)};
                    w_k = w_k + 1'b1;
                end
            endcase
            if (n_bytes_left == 16'd0) begin
                w_finish = 1'b1;
            end
        end

        // Part trailer
        if (w_finish) begin
            if (n_type == TYPE_INT) begin
                if (len_ok(n_decl_len)) begin
                    // Little-endian hold buffer goes out most significant byte first
                    for (int i = 0; i < HOLD_DEPTH; i++) begin
                        if (16'(i) < n_decl_len) begin
                            w_res[w_k + RES_W'(i)] = '{
                                data: n_hold[3'(n_decl_len[HOLD_W-1:0] - 3'(i) - 3'd1)]
                                      ^ ((i == 0) ? SIGN_FLIP : 8'h00),
                                part_end: (16'(i + 1) == n_decl_len)};
                        end
                    end
                    w_k = w_k + n_decl_len[RES_W-1:0];
                end
            end else if (n_type == TYPE_STRING) begin
                w_res[w_k] = '{data: TERMINATOR, part_end: 1'b0};
                w_k = w_k + 1'b1;
                w_res[w_k] = '{data: n_decl_len[15:8], part_end: 1'b0};
                w_k = w_k + 1'b1;
                w_res[w_k] = '{data: n_decl_len[7:0], part_end: 1'b1};
                w_k = w_k + 1'b1;
            end else if ((n_type == TYPE_DATETIME) && n_reorder) begin
                // Date bytes reversed; bytes never received read as zero
                for (int j = 2; j >= 0; j--) begin
                    w_res[w_k] = '{data: (n_held > HELD_W'(j)) ? n_hold[HOLD_W'(j)] : 8'h00,
                                   part_end: (j == 0)};
                    w_k = w_k + 1'b1;
                end
            end
        end
    end

    assign o_burst.res = w_res;
    assign o_burst.cnt = w_k;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_type       <= TYPE_INT;
            r_reorder    <= 1'b0;
            r_decl_len   <= '0;
            r_held       <= '0;
        end else if (i_fire) begin
            r_bytes_left <= n_bytes_left;
            r_type       <= n_type;
            r_reorder    <= n_reorder;
            r_decl_len   <= n_decl_len;
            r_held       <= n_held;
        end
    end

    // Hold buffer contents, only meaningful below the held count
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hold <= n_hold;
        end
    end

endmodule

// ----- rtl/ske_outbuf.sv -----
// Result burst register and byte serializer for the encoder output channel.
`timescale 1ns / 1ps

module ske_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ske_pkg::t_burst i_burst,
    output logic            o_can_load,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_part_end
);
    import ske_pkg::*;

    t_res [MAX_RES-1:0] r_res;
    logic [RES_W-1:0]   r_cnt;
    logic [RES_W-1:0]   r_idx;
    logic               w_last;
    logic               w_take;

    // Serializer status
    assign w_last     = (r_idx == (r_cnt - 1'b1));
    assign o_valid    = (r_cnt != '0);
    assign w_take     = o_valid && !i_stall;
    assign o_can_load = !o_valid || (w_take && w_last);

    assign o_out_byte = r_res[r_idx].data;
    assign o_part_end = r_res[r_idx].part_end;
    assign o_run_last = w_last;

    // Burst count and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
            r_idx <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Burst bytes
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end
    end

endmodule
